// File: rtl/core/modexp_pkg.sv
// Shared widths and register indexes of the modular exponentiation unit.
package modexp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

endpackage

// File: rtl/core/modexp_if.sv
// Valid/ready channel interfaces: base items in, results out, register writes.
interface modexp_in_if;
    logic                          valid;
    logic                          ready;
    logic [modexp_pkg::DATA_W-1:0] base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

interface modexp_out_if;
    logic                          valid;
    logic                          ready;
    logic [modexp_pkg::DATA_W-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

interface modexp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [modexp_pkg::CFG_IDX_W-1:0] index;
    logic [modexp_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/modular_exponentiation_unit.sv
// Microcoded square-and-multiply unit computing base^exponent mod modulus.
// The modular multiplier is bit-serial: a doubling step and an add step per multiplier bit.
// Throughput: one item in flight; the next is taken once the result is registered.
// Reset (synchronous, active low): exponent 0, modulus 1, sequencer idle, output empty.
module modular_exponentiation_unit #(
    parameter int OPERAND_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    modexp_cfg_if.sink    i_cfg,
    modexp_in_if.sink     i_in,
    modexp_out_if.source  o_out
);
    import modexp_pkg::*;

    localparam int W     = OPERAND_BITS;
    localparam int CNT_W = $clog2(W);

    typedef logic [3:0] t_pc;

    typedef enum logic [2:0] {
        UOP_LOAD,
        UOP_LD_SQ,
        UOP_LD_MU,
        UOP_DBL,
        UOP_ADD,
        UOP_ACC_R,
        UOP_EDEC,
        UOP_EMIT
    } t_uop_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_LOOP_CNT,
        C_SKIP_EBIT,
        C_LOOP_E,
        C_WAIT_OUT
    } t_uop_cond;

    typedef struct packed {
        t_uop_op   op;
        t_uop_cond cond;
        t_pc       target;
    } t_uop;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_SQ_SET = 4'd1;
    localparam t_pc PC_SQ_DBL = 4'd2;
    localparam t_pc PC_MU_DBL = 4'd6;
    localparam t_pc PC_NEXT   = 4'd9;
    localparam int  N_STEPS   = 11;

    localparam t_uop PROGRAM [N_STEPS] = '{
        '{UOP_LOAD,  C_WAIT_IN,   PC_IDLE},    // wait for base
        '{UOP_LD_SQ, C_NEXT,      PC_IDLE},    // square: r=0, y=acc
        '{UOP_DBL,   C_NEXT,      PC_IDLE},
        '{UOP_ADD,   C_LOOP_CNT,  PC_SQ_DBL},
        '{UOP_ACC_R, C_SKIP_EBIT, PC_NEXT},
        '{UOP_LD_MU, C_NEXT,      PC_IDLE},    // multiply: r=0, y=base
        '{UOP_DBL,   C_NEXT,      PC_IDLE},
        '{UOP_ADD,   C_LOOP_CNT,  PC_MU_DBL},
        '{UOP_ACC_R, C_NEXT,      PC_IDLE},
        '{UOP_EDEC,  C_LOOP_E,    PC_SQ_SET},
        '{UOP_EMIT,  C_WAIT_OUT,  PC_IDLE}
    };

    logic [W-1:0]     r_exp, r_mod, r_base, r_acc, r_r, r_y;
    logic [CNT_W-1:0] r_cnt, r_eidx;
    t_pc              r_pc;
    logic             r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    t_uop         uop;
    logic         in_acc, out_free, cfg_acc;
    logic [W:0]   dbl_sum, add_sum, n_dbl, n_add;
    logic [W-1:0] n_r;
    t_pc          n_pc;

    assign uop      = PROGRAM[r_pc];
    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // registers change only while idle; a pending write goes ahead of the next item
    assign i_in.ready      = (uop.cond == C_WAIT_IN) && !i_cfg.valid;
    assign i_cfg.ready     = (uop.cond == C_WAIT_IN);
    assign o_out.valid     = r_out_valid;
    assign o_out.power_mod = r_out_data;

    // modular doubling (a shift) and modular addition, each one compare and a conditional subtract of the modulus
    always_comb begin
        dbl_sum = {r_r, 1'b0};
        n_dbl   = (dbl_sum >= {1'b0, r_mod}) ? dbl_sum - {1'b0, r_mod} : dbl_sum;
        add_sum = {1'b0, r_r} + {1'b0, r_acc};
        n_add   = (add_sum >= {1'b0, r_mod}) ? add_sum - {1'b0, r_mod} : add_sum;
        n_r     = r_y[W-1] ? n_add[W-1:0] : r_r;
    end

    always_comb begin
        n_pc = r_pc + 4'd1;
        case (uop.cond)
            C_NEXT:      n_pc = r_pc + 4'd1;
            C_WAIT_IN:   n_pc = in_acc ? r_pc + 4'd1 : r_pc;
            C_LOOP_CNT:  n_pc = (r_cnt != '0) ? uop.target : r_pc + 4'd1;
            C_SKIP_EBIT: n_pc = r_exp[r_eidx] ? r_pc + 4'd1 : uop.target;
            C_LOOP_E:    n_pc = (r_eidx != '0) ? uop.target : r_pc + 4'd1;
            C_WAIT_OUT:  n_pc = out_free ? uop.target : r_pc;
            default:     n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
            r_exp       <= '0;
            r_mod       <= W'(1);
        end else begin
            r_pc <= n_pc;

            if (cfg_acc) begin
                case (i_cfg.index)
                    REG_EXPONENT: r_exp <= i_cfg.data[W-1:0];
                    REG_MODULUS:  r_mod <= i_cfg.data[W-1:0];
                    default: ;
                endcase
            end

            if (uop.op == UOP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (uop.op)
                UOP_LOAD: begin
                    if (in_acc) begin
                        r_base <= i_in.base[W-1:0];
                        r_acc  <= (r_mod == W'(1)) ? '0 : W'(1);
                        r_eidx <= CNT_W'(W - 1);
                    end
                end
                UOP_LD_SQ: begin
                    r_r   <= '0;
                    r_y   <= r_acc;
                    r_cnt <= CNT_W'(W - 1);
                end
                UOP_LD_MU: begin
                    r_r   <= '0;
                    r_y   <= r_base;
                    r_cnt <= CNT_W'(W - 1);
                end
                UOP_DBL: begin
                    r_r <= n_dbl[W-1:0];
                end
                UOP_ADD: begin
                    r_r <= n_r;
                    r_y <= {r_y[W-2:0], 1'b0};
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                UOP_ACC_R: begin
                    r_acc <= r_r;
                end
                UOP_EDEC: begin
                    if (r_eidx != '0) begin
                        r_eidx <= r_eidx - CNT_W'(1);
                    end
                end
                UOP_EMIT: begin
                    if (out_free) begin
                        r_out_data <= (r_mod == '0) ? '0 : DATA_W'(r_acc);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: sim/modular_exponentiation_unit_test.sv
// Testbench for modular_exponentiation_unit: directed key/base table, then random key phases.
module modular_exponentiation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    localparam int  DIRECTED_ROWS = 21;
    localparam int  PHASES        = 7;
    localparam int  PHASE_ITEMS   = 17;
    localparam int  HOLD_AT       = 70;
    localparam int  HOLD_CYCLES   = 12000;
    localparam int  SETTLE_CYCLES = 4500;
    localparam longint LIMIT      = 3000000;

    typedef struct packed {
        logic [DATA_W-1:0] exponent;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] base;
        logic              known;
        logic [DATA_W-1:0] power_mod;
    } vector_t;

    localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'd0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd1},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'd0},
        '{32'h0000_0001, 32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b1, 32'd4},
        '{32'h0000_0001, 32'hFFFF_FFFB, 32'h1234_5678, 1'b1, 32'h1234_5678},
        '{32'd17,        32'd3233,      32'd65,        1'b1, 32'd2790},
        '{32'd2753,      32'd3233,      32'd2790,      1'b1, 32'd65},
        '{32'd2753,      32'd3233,      32'd0,         1'b1, 32'd0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'h0000_0002, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'h8000_0000, 32'hFFFF_FFFB, 32'h0000_0002, 1'b0, 32'd0},
        '{32'h0000_0002, 32'h0001_0000, 32'h0000_FFFF, 1'b0, 32'd0},
        '{32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h5555_5555, 1'b0, 32'd0},
        '{32'h5555_5555, 32'h8000_0001, 32'hAAAA_AAAA, 1'b0, 32'd0}
    };

    logic i_clk;
    logic i_rst_n;

    modexp_cfg_if cfg_if ();
    modexp_in_if  in_if ();
    modexp_out_if out_if ();

    modular_exponentiation_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [DATA_W-1:0] key_exponent;
    logic [DATA_W-1:0] key_modulus;
    logic [DATA_W-1:0] pending_powers [$];
    logic              steady;
    logic              hold_done;
    int                hold_left;
    int                bases_taken;
    int                powers_checked = 0;
    int                reg_writes;
    int                failures = 0;
    longint            cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] power_mod_of(input logic [DATA_W-1:0] b,
                                                       input logic [DATA_W-1:0] e,
                                                       input logic [DATA_W-1:0] m);
        logic [63:0] acc;
        if (m == '0) begin
            return '0;
        end
        acc = 64'd1 % 64'(m);
        for (int i = DATA_W - 1; i >= 0; i--) begin
            acc = (acc * acc) % 64'(m);
            if (e[i]) begin
                acc = (acc * 64'(b)) % 64'(m);
            end
        end
        return acc[DATA_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == REG_EXPONENT) begin
            key_exponent = value;
        end else if (idx == REG_MODULUS) begin
            key_modulus = value;
        end
        reg_writes++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    // block is idle once every result is out; an unmapped index rides along
    task automatic load_key(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] m);
        drain();
        write_reg(REG_EXPONENT, e);
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_MODULUS) + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom);
        write_reg(REG_MODULUS, m);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_base(input logic [DATA_W-1:0] b, input logic known,
                             input logic [DATA_W-1:0] typed);
        if (!steady && $urandom_range(99) < 10) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.base  <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_powers.push_back(known ? typed : power_mod_of(b, key_exponent, key_modulus));
        bases_taken++;
    endtask

    function automatic logic [DATA_W-1:0] pick_base(input logic [DATA_W-1:0] m);
        case ($urandom_range(11))
            0:       return '0;
            1:       return 32'd1;
            2:       return m - 1;
            3:       return m;
            4:       return m + 1;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random idles, one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (!hold_done && bases_taken >= HOLD_AT) begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_powers.size() == 0) begin
                $error("power_mod: no item pending, got %h", out_if.power_mod);
                failures++;
            end else begin
                if (out_if.power_mod !== pending_powers[0]) begin
                    $error("power_mod: expected %h, got %h", pending_powers[0],
                           out_if.power_mod);
                    failures++;
                end
                void'(pending_powers.pop_front());
                powers_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("modular_exponentiation_unit verification failed");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] m;
        bases_taken    = 0;
        reg_writes     = 0;
        steady         = 1'b0;
        key_exponent   = '0;
        key_modulus    = 32'd1;
        i_rst_n        <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        in_if.valid    <= 1'b0;
        in_if.base     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].exponent != key_exponent || DIRECTED[r].modulus != key_modulus) begin
                load_key(DIRECTED[r].exponent, DIRECTED[r].modulus);
            end
            send_base(DIRECTED[r].base, DIRECTED[r].known, DIRECTED[r].power_mod);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin e = 32'h0001_0001;                   m = $urandom | 32'h8000_0001; end
                1: begin e = $urandom;                        m = $urandom | 32'h8000_0000; end
                2: begin e = $urandom;                        m = $urandom_range(2, 1000); end
                3: begin e = 32'hFFFF_FFFF;                   m = $urandom | 32'd2; end
                4: begin e = 32'd1 << $urandom_range(31);     m = 32'hFFFF_FFFF; end
                5: begin e = $urandom;                        m = 32'd1; end
                default: begin e = $urandom;                  m = $urandom | 32'd1; end
            endcase
            load_key(e, m);
            steady = (p == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_base(pick_base(m), 1'b0, '0);
            end
            steady = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d bases (%0d from the table), %0d register writes, %0d results checked",
                 bases_taken, DIRECTED_ROWS, reg_writes, powers_checked);
        $display("keys spanned exponent 0..all ones and modulus 0, 1, small and full width");
        if (failures == 0) begin
            $display("modular_exponentiation_unit verification clean");
        end else begin
            $display("modular_exponentiation_unit verification failed");
        end
        $finish;
    end

endmodule
